// ===== rtl/ght_pkg.sv =====
// shared types, constants and codes of the generational handle table
`timescale 1ns / 1ps

package ght_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int GEN_BITS    = 16;
  localparam int IDX_W       = $clog2(SLOT_COUNT);
  localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
  localparam int REF_W       = 16;
  localparam int BYTE_W      = 32;
  localparam int TOTAL_W     = 38;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  localparam logic [2:0] OPC_CREATE  = 3'd0;
  localparam logic [2:0] OPC_ADDREF  = 3'd1;
  localparam logic [2:0] OPC_RELEASE = 3'd2;
  localparam logic [2:0] OPC_DESTROY = 3'd3;
  localparam logic [2:0] OPC_CHECK   = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef enum logic [2:0] {
    OP_CREATE,
    OP_ADDREF,
    OP_RELEASE,
    OP_DESTROY,
    OP_CHECK,
    OP_BAD
  } op_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [IDX_W-1:0]  slot_index;
    logic [15:0]       handle_generation;
    logic [BYTE_W-1:0] byte_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   result_index;
    logic [15:0]        result_generation;
    logic [REF_W-1:0]   ref_count;
    logic               was_destroyed;
    logic [CNT_W-1:0]   live_count;
    logic [TOTAL_W-1:0] memory_in_use;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic [15:0]       gen;
    logic [BYTE_W-1:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic [GEN_BITS-1:0] gen;
    logic [REF_W-1:0]    refs;
    logic [BYTE_W-1:0]   bytes;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ===== rtl/generational_handle_table.sv =====
// top level of the generational handle table
`timescale 1ns / 1ps

// A table of 64 handle slots, each with a generation, live flag, reference count
// and byte size, driven by create, add reference, release, destroy and check items.
// Every input item gives exactly one result item, in order. In the back end an item
// goes through command pop with slot entry read, then update and result; a
// create that reuses a freed slot has a free-stack read first, which must finish
// before the slot entry read. These steps come from the back-end sequencer and
// the registered reads of the slot and free-stack rams. A two-entry queue lets the
// front end keep taking items while the back end works, and the result register
// lets the next item proceed until its own result is ready. Live flags clear at
// reset, so the block accepts items right after reset with no clearing pass.
module generational_handle_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ght_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ght_pkg::out_item_t out_item_o
);

  logic          q_valid;
  logic          q_pop;
  ght_pkg::cmd_t q_cmd;

  ght_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_cmd_o    (q_cmd)
  );

  ght_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_cmd_i     (q_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/ght_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ght_front.sv =====
// front end: accepts items, classifies the opcode and buffers commands
`timescale 1ns / 1ps

module ght_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ght_pkg::in_item_t in_item_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output ght_pkg::cmd_t     q_cmd_o
);

  ght_pkg::cmd_t                 fifo_q [ght_pkg::QUEUE_DEPTH];
  logic [ght_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [ght_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ght_pkg::QCNT_W-1:0]    count_q, count_d;
  ght_pkg::cmd_t                 cmd;
  logic                          push;
  logic                          pop;

  always_comb begin
    cmd.idx   = in_item_i.slot_index;
    cmd.gen   = in_item_i.handle_generation;
    cmd.bytes = in_item_i.byte_size;
    case (in_item_i.opcode)
      ght_pkg::OPC_CREATE:  cmd.op = ght_pkg::OP_CREATE;
      ght_pkg::OPC_ADDREF:  cmd.op = ght_pkg::OP_ADDREF;
      ght_pkg::OPC_RELEASE: cmd.op = ght_pkg::OP_RELEASE;
      ght_pkg::OPC_DESTROY: cmd.op = ght_pkg::OP_DESTROY;
      ght_pkg::OPC_CHECK:   cmd.op = ght_pkg::OP_CHECK;
      default:              cmd.op = ght_pkg::OP_BAD;
    endcase
  end

  assign in_stall_o = (count_q == ght_pkg::QCNT_W'(ght_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

// ===== rtl/ght_back.sv =====
// back end: slot table sequencer, free stack, totals and result register
`timescale 1ns / 1ps

module ght_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  ght_pkg::cmd_t      q_cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ght_pkg::out_item_t out_item_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STACK,
    ST_EXEC
  } state_e;

  state_e                           st_q, st_d;
  ght_pkg::cmd_t                    cur_q, cur_d;
  logic                             from_stack_q, from_stack_d;
  logic [ght_pkg::IDX_W-1:0]        slot_q, slot_d;
  logic [ght_pkg::CNT_W-1:0]        free_top_q, free_top_d;
  logic [ght_pkg::CNT_W-1:0]        opened_q, opened_d;
  logic [ght_pkg::CNT_W-1:0]        live_total_q, live_total_d;
  logic [ght_pkg::TOTAL_W-1:0]      bytes_total_q, bytes_total_d;
  logic [ght_pkg::SLOT_COUNT-1:0]   live_q, live_d;
  logic                             out_valid_q, out_valid_d;
  ght_pkg::out_item_t               out_q, out_d;

  logic                             slot_we, slot_re;
  logic [ght_pkg::IDX_W-1:0]        slot_waddr, slot_raddr;
  ght_pkg::slot_entry_t             slot_wdata, slot_rd;
  logic [ght_pkg::ENTRY_W-1:0]      slot_rdata;
  logic                             stack_we, stack_re;
  logic [ght_pkg::IDX_W-1:0]        stack_waddr, stack_raddr, stack_rdata;
  logic [ght_pkg::CNT_W-1:0]        top_m1;
  logic                             out_free;
  logic                             hit;
  logic                             do_free;
  logic [ght_pkg::REF_W-1:0]        new_refs;
  logic [ght_pkg::GEN_BITS-1:0]     new_gen;
  logic [ght_pkg::IDX_W-1:0]        new_slot;

  assign slot_rd  = ght_pkg::slot_entry_t'(slot_rdata);
  assign top_m1   = free_top_q - ght_pkg::CNT_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;
  assign hit      = (ght_pkg::CNT_W'(cur_q.idx) < opened_q) && live_q[cur_q.idx]
                    && (slot_rd.gen == cur_q.gen);

  ght_ram #(
    .WIDTH (ght_pkg::ENTRY_W),
    .DEPTH (ght_pkg::SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  ght_ram #(
    .WIDTH (ght_pkg::IDX_W),
    .DEPTH (ght_pkg::SLOT_COUNT)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (stack_waddr),
    .wdata_i (cur_q.idx),
    .re_i    (stack_re),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  always_comb begin
    st_d          = st_q;
    cur_d         = cur_q;
    from_stack_d  = from_stack_q;
    slot_d        = slot_q;
    free_top_d    = free_top_q;
    opened_d      = opened_q;
    live_total_d  = live_total_q;
    bytes_total_d = bytes_total_q;
    live_d        = live_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    q_pop_o       = 1'b0;
    slot_re       = 1'b0;
    slot_raddr    = q_cmd_i.idx;
    slot_we       = 1'b0;
    slot_waddr    = cur_q.idx;
    slot_wdata    = slot_rd;
    stack_re      = 1'b0;
    stack_raddr   = top_m1[ght_pkg::IDX_W-1:0];
    stack_we      = 1'b0;
    stack_waddr   = free_top_q[ght_pkg::IDX_W-1:0];
    do_free       = 1'b0;
    new_refs      = slot_rd.refs;
    new_gen       = '0;
    new_slot      = opened_q[ght_pkg::IDX_W-1:0];

    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_cmd_i;
          st_d    = ST_EXEC;
          case (q_cmd_i.op)
            ght_pkg::OP_CREATE: begin
              from_stack_d = (free_top_q != '0);
              if (free_top_q != '0) begin
                stack_re = 1'b1;
                st_d     = ST_STACK;
              end
            end
            ght_pkg::OP_ADDREF, ght_pkg::OP_RELEASE,
            ght_pkg::OP_DESTROY, ght_pkg::OP_CHECK: begin
              slot_re = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_STACK: begin
        slot_d     = stack_rdata;
        slot_re    = 1'b1;
        slot_raddr = stack_rdata;
        st_d       = ST_EXEC;
      end

      ST_EXEC: begin
        if (out_free) begin
          st_d                    = ST_IDLE;
          out_valid_d             = 1'b1;
          out_d.status            = ght_pkg::STATUS_OK;
          out_d.result_index      = cur_q.idx;
          out_d.result_generation = cur_q.gen;
          out_d.ref_count         = '0;
          out_d.was_destroyed     = 1'b0;
          case (cur_q.op)
            ght_pkg::OP_CREATE: begin
              if (from_stack_q || opened_q != ght_pkg::CNT_W'(ght_pkg::SLOT_COUNT)) begin
                if (from_stack_q) begin
                  new_slot   = slot_q;
                  new_gen    = slot_rd.gen + 1'b1;
                  free_top_d = top_m1;
                end else begin
                  opened_d = opened_q + 1'b1;
                end
                slot_we                 = 1'b1;
                slot_waddr              = new_slot;
                slot_wdata.gen          = new_gen;
                slot_wdata.refs         = '0;
                slot_wdata.bytes        = cur_q.bytes;
                live_d[new_slot]        = 1'b1;
                live_total_d            = live_total_q + 1'b1;
                bytes_total_d           = bytes_total_q
                                          + ght_pkg::TOTAL_W'(cur_q.bytes);
                out_d.result_index      = new_slot;
                out_d.result_generation = new_gen;
              end else begin
                out_d.status            = ght_pkg::STATUS_FULL;
                out_d.result_index      = '0;
                out_d.result_generation = '0;
              end
            end
            ght_pkg::OP_ADDREF, ght_pkg::OP_RELEASE,
            ght_pkg::OP_DESTROY, ght_pkg::OP_CHECK: begin
              if (!hit) begin
                out_d.status = ght_pkg::STATUS_INVALID;
              end else begin
                out_d.result_generation = slot_rd.gen;
                case (cur_q.op)
                  ght_pkg::OP_ADDREF: begin
                    if (slot_rd.refs != ght_pkg::REF_MAX) begin
                      new_refs = slot_rd.refs + 1'b1;
                    end
                    slot_we = 1'b1;
                  end
                  ght_pkg::OP_RELEASE: begin
                    if (slot_rd.refs != '0) begin
                      new_refs = slot_rd.refs - 1'b1;
                    end
                    slot_we = 1'b1;
                    do_free = (new_refs == '0);
                  end
                  ght_pkg::OP_DESTROY: begin
                    new_refs = '0;
                    slot_we  = 1'b1;
                    do_free  = 1'b1;
                  end
                  default: begin
                  end
                endcase
                slot_wdata.refs = new_refs;
                out_d.ref_count = new_refs;
                if (do_free) begin
                  live_d[cur_q.idx]   = 1'b0;
                  bytes_total_d       = bytes_total_q
                                        - ght_pkg::TOTAL_W'(slot_rd.bytes);
                  out_d.was_destroyed = 1'b1;
                  if (live_total_q != '0) begin
                    live_total_d = live_total_q - 1'b1;
                  end
                  if (free_top_q != ght_pkg::CNT_W'(ght_pkg::SLOT_COUNT)) begin
                    stack_we   = 1'b1;
                    free_top_d = free_top_q + 1'b1;
                  end
                end
              end
            end
            default: begin
              out_d.status = ght_pkg::STATUS_INVALID;
            end
          endcase
          out_d.live_count    = live_total_d;
          out_d.memory_in_use = bytes_total_d;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_IDLE;
      cur_q         <= ght_pkg::cmd_t'('0);
      from_stack_q  <= 1'b0;
      slot_q        <= '0;
      free_top_q    <= '0;
      opened_q      <= '0;
      live_total_q  <= '0;
      bytes_total_q <= '0;
      live_q        <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      st_q          <= st_d;
      cur_q         <= cur_d;
      from_stack_q  <= from_stack_d;
      slot_q        <= slot_d;
      free_top_q    <= free_top_d;
      opened_q      <= opened_d;
      live_total_q  <= live_total_d;
      bytes_total_q <= bytes_total_d;
      live_q        <= live_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
